[rtl/bdne_pkg.sv]
`default_nettype none
package bdne_pkg;

  localparam int LANES       = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int BTN_WIDTH   = 8;

  localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [1:0] REG_LOCKOUT_TICKS = 2'd0;
  localparam logic [1:0] REG_MIDI_CHANNEL  = 2'd1;
  localparam logic [1:0] REG_NOTE_MAP      = 2'd2;

  localparam logic [15:0] LOCKOUT_RESET = 16'd20;

  localparam logic [3:0] CIN_NOTE_ON   = 4'd9;
  localparam logic [3:0] CIN_NOTE_OFF  = 4'd8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [6:0] VEL_ON        = 7'd127;
  localparam logic [6:0] VEL_OFF       = 7'd0;

  typedef enum logic [3:0] {
    PH_IDLE_UP   = 4'b0001,
    PH_LOCK_DOWN = 4'b0010,
    PH_IDLE_DOWN = 4'b0100,
    PH_LOCK_UP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic fire;
    logic press;
  } lane_ev_t;

  function automatic logic [COUNT_WIDTH-1:0] clamp_ticks(input logic [15:0] v);
    logic [31:0] w;
    w = {16'd0, v};
    if (w == 32'd0) begin
      w = 32'd1;
    end
    if (w > CNT_MAX32) begin
      w = CNT_MAX32;
    end
    return w[COUNT_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/bdne_lane.sv]
`default_nettype none
module bdne_lane
  import bdne_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic                   pressed,
  input  wire logic [COUNT_WIDTH-1:0] ticks,
  output lane_ev_t                    ev
);

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  assign cnt_dec = (cnt_r != '0) ? cnt_r - 1'b1 : '0;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ev.fire   = 1'b0;
    ev.press  = 1'b0;
    unique case (phase_r)
      PH_IDLE_UP: begin
        if (pressed) begin
          cnt_nxt   = ticks;
          phase_nxt = PH_LOCK_DOWN;
          ev.fire   = 1'b1;
          ev.press  = 1'b1;
        end
      end
      PH_LOCK_DOWN: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          phase_nxt = PH_IDLE_DOWN;
        end
      end
      PH_IDLE_DOWN: begin
        if (!pressed) begin
          cnt_nxt   = ticks;
          phase_nxt = PH_LOCK_UP;
          ev.fire   = 1'b1;
        end
      end
      PH_LOCK_UP: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          phase_nxt = PH_IDLE_UP;
        end
      end
      default: begin
        phase_nxt = PH_IDLE_UP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE_UP;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/bdne_merge.sv]
`default_nettype none
module bdne_merge
  import bdne_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  lane_ev_t [LANES-1:0]     lane_ev,
  input  wire logic [3:0]          channel,
  input  wire logic [63:0]         note_map,
  output logic                     busy,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [3:0]               out_code_index,
  output logic [7:0]               out_status_byte,
  output logic [7:0]               out_note_number,
  output logic [6:0]               out_velocity,
  output logic                     out_last_event
);

  logic [LANES-1:0] pend_r, pend_nxt;
  logic [LANES-1:0] press_r, press_nxt;
  logic [LANES-1:0] sel, fire_vec, press_vec;
  logic             load, sel_press;
  logic [7:0]       sel_note;
  logic             out_valid_r;
  logic [3:0]       code_r;
  logic [7:0]       status_r, note_r;
  logic [6:0]       vel_r;
  logic             last_r;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      fire_vec[k]  = lane_ev[k].fire;
      press_vec[k] = lane_ev[k].press;
    end
  end

  assign sel       = pend_r & (~pend_r + LANES'(1));
  assign sel_press = |(sel & press_r);
  assign load      = (pend_r != '0) && (!out_valid_r || !out_stall);

  always_comb begin
    sel_note = 8'd0;
    for (int k = 0; k < LANES; k++) begin
      if (sel[k]) begin
        sel_note = sel_note | note_map[8*(k%8) +: 8];
      end
    end
  end

  assign busy = (pend_r & ~(load ? sel : '0)) != '0;

  always_comb begin
    pend_nxt  = pend_r;
    press_nxt = press_r;
    if (load) begin
      pend_nxt = pend_r & ~sel;
    end
    if (step) begin
      pend_nxt  = fire_vec;
      press_nxt = press_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    press_r <= press_nxt;
    if (load) begin
      code_r   <= sel_press ? CIN_NOTE_ON : CIN_NOTE_OFF;
      status_r <= {(sel_press ? STAT_NOTE_ON : STAT_NOTE_OFF), channel};
      note_r   <= sel_note;
      vel_r    <= sel_press ? VEL_ON : VEL_OFF;
      last_r   <= (pend_r & ~sel) == '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_index  = code_r;
  assign out_status_byte = status_r;
  assign out_note_number = note_r;
  assign out_velocity    = vel_r;
  assign out_last_event  = last_r;

endmodule
`default_nettype wire

[rtl/button_debounce_note_events.sv]
// Path: a sample's events are held in a pending mask, then in the output register.
// Throughput: the merge stage sends one event per cycle while out_stall is low; a
// new sample waits until the last event is loaded, and holds at most eight events.
// Reset: synchronous, active low; all lanes return to idle-released with zero
// counters, lockout ticks to 20, channel and note map to zero.
`default_nettype none
module button_debounce_note_events
  import bdne_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BTN_WIDTH-1:0] in_button_levels,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [3:0]                out_code_index,
  output logic [7:0]                out_status_byte,
  output logic [7:0]                out_note_number,
  output logic [6:0]                out_velocity,
  output logic                      out_last_event,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_wdata
);

  logic [COUNT_WIDTH-1:0] ticks_r;
  logic [3:0]             channel_r;
  logic [63:0]            note_map_r;
  logic                   step;
  logic                   busy;
  lane_ev_t [LANES-1:0]   lane_ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= clamp_ticks(LOCKOUT_RESET);
      channel_r  <= 4'd0;
      note_map_r <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCKOUT_TICKS: ticks_r    <= clamp_ticks(cfg_wdata[15:0]);
        REG_MIDI_CHANNEL:  channel_r  <= cfg_wdata[3:0];
        REG_NOTE_MAP:      note_map_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = busy;
  assign step     = in_valid && !busy;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic pressed;
    if (k < BTN_WIDTH) begin : g_btn
      assign pressed = ~in_button_levels[k];
    end else begin : g_none
      assign pressed = 1'b0;
    end
    bdne_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (step),
      .pressed (pressed),
      .ticks   (ticks_r),
      .ev      (lane_ev[k])
    );
  end

  bdne_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .lane_ev         (lane_ev),
    .channel         (channel_r),
    .note_map        (note_map_r),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_index  (out_code_index),
    .out_status_byte (out_status_byte),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_last_event  (out_last_event)
  );

endmodule
`default_nettype wire

[rtl/bdne_checker.sv]
`default_nettype none
module bdne_checker
  import bdne_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [3:0]           out_code_index,
  input wire logic [7:0]           out_status_byte,
  input wire logic [7:0]           out_note_number,
  input wire logic [6:0]           out_velocity,
  input wire logic                 out_last_event
);

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status_byte)
      && $stable(out_note_number) && $stable(out_last_event)))
    else $error("stalled result changed");

  // Note-on and note-off carry consistent code, velocity and status.
  a_on_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code_index == CIN_NOTE_ON) |->
      (out_velocity == VEL_ON && out_status_byte[7:4] == STAT_NOTE_ON))
    else $error("note-on fields inconsistent");

  a_off_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code_index != CIN_NOTE_ON) |->
      (out_code_index == CIN_NOTE_OFF && out_velocity == VEL_OFF
       && out_status_byte[7:4] == STAT_NOTE_OFF))
    else $error("note-off fields inconsistent");

  // Events of one sample follow each other without a gap.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_event) |=> out_valid)
    else $error("gap inside an event burst");

endmodule

bind button_debounce_note_events bdne_checker u_bdne_checker (.*);
`default_nettype wire

[tb/button_debounce_note_events_tb.sv]
`timescale 1ns / 100ps
module button_debounce_note_events_tb;
  import bdne_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] status_byte;
    logic [7:0] note_number;
    logic [6:0] velocity;
    logic       last_event;
  } note_event_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_index;
    logic [63:0] wdata;
    logic [7:0]  levels;
    logic        typed;
    logic [3:0]  typed_count;
    note_event_t typed_event;
  } row_t;

  localparam note_event_t NO_EVENT = '0;
  localparam note_event_t ON_C0_N00 = '{CIN_NOTE_ON, {STAT_NOTE_ON, 4'h0}, 8'h00, VEL_ON, 1'b0};
  localparam note_event_t ON_CF_NFF = '{CIN_NOTE_ON, {STAT_NOTE_ON, 4'hF}, 8'hFF, VEL_ON, 1'b0};
  localparam note_event_t OFF_CF_NFF =
    '{CIN_NOTE_OFF, {STAT_NOTE_OFF, 4'hF}, 8'hFF, VEL_OFF, 1'b0};

  localparam int DIRECTED_ROWS = 23;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFF, 1'b1, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'h7F, 1'b1, 4'd1, ON_C0_N00},
    '{ROW_WRITE, REG_LOCKOUT_TICKS, 64'd0, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_WRITE, REG_MIDI_CHANNEL, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_WRITE, REG_NOTE_MAP, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFE, 1'b1, 4'd1, ON_CF_NFF},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFF, 1'b1, 4'd1, OFF_CF_NFF},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'h00, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'h00, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'h00, 1'b0, 4'd0, NO_EVENT},
    '{ROW_WRITE, REG_NOTE_MAP, 64'h0123_4567_89AB_CDEF, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_WRITE, REG_LOCKOUT_TICKS, 64'hFFFF_FFFF_0001_0003, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_WRITE, REG_UNUSED, 64'h0000_0000_0000_0007, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hAA, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'h55, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFF, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'h00, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'h0F, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hF0, 1'b0, 4'd0, NO_EVENT},
    '{ROW_SAMPLE, 2'd0, 64'd0, 8'hFF, 1'b0, 4'd0, NO_EVENT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BTN_WIDTH-1:0] in_button_levels = '1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [3:0]           out_code_index;
  logic [7:0]           out_status_byte;
  logic [7:0]           out_note_number;
  logic [6:0]           out_velocity;
  logic                 out_last_event;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [63:0]          cfg_wdata = '0;

  phase_t                 lane_phase [LANES];
  logic [COUNT_WIDTH-1:0] lane_count [LANES];
  logic [COUNT_WIDTH-1:0] ticks_cfg;
  logic [3:0]             chan_cfg;
  logic [63:0]            map_cfg;

  note_event_t tick_events [8];
  note_event_t pending_events [$];
  logic [7:0]  held_levels = 8'hFF;

  int send_idle_pct = 27;
  int recv_idle_pct = 85;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned notes_on = 0;
  int unsigned notes_off = 0;
  int unsigned reg_writes = 0;
  int unsigned drain_pauses = 0;

  button_debounce_note_events u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button_levels (in_button_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_index   (out_code_index),
    .out_status_byte  (out_status_byte),
    .out_note_number  (out_note_number),
    .out_velocity     (out_velocity),
    .out_last_event   (out_last_event),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d events outstanding.",
               cycle_count, pending_events.size());
      $display("button_debounce_note_events regression: fail");
      $finish;
    end
  end

  function automatic int debounce_tick(input logic [7:0] levels);
    int n;
    logic pressed;
    logic fire;
    logic is_press;
    note_event_t ev;
    n = 0;
    is_press = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      pressed = (k < 8) ? ~levels[k % 8] : 1'b0;
      fire = 1'b0;
      unique case (lane_phase[k])
        PH_IDLE_UP: begin
          if (pressed) begin
            lane_count[k] = ticks_cfg;
            lane_phase[k] = PH_LOCK_DOWN;
            fire = 1'b1;
            is_press = 1'b1;
          end
        end
        PH_LOCK_DOWN: begin
          if (lane_count[k] != '0) lane_count[k] = lane_count[k] - 1'b1;
          if (lane_count[k] == '0) lane_phase[k] = PH_IDLE_DOWN;
        end
        PH_IDLE_DOWN: begin
          if (!pressed) begin
            lane_count[k] = ticks_cfg;
            lane_phase[k] = PH_LOCK_UP;
            fire = 1'b1;
            is_press = 1'b0;
          end
        end
        default: begin
          if (lane_count[k] != '0) lane_count[k] = lane_count[k] - 1'b1;
          if (lane_count[k] == '0) lane_phase[k] = PH_IDLE_UP;
        end
      endcase
      if (fire && n < 8) begin
        ev.code_index  = is_press ? CIN_NOTE_ON : CIN_NOTE_OFF;
        ev.status_byte = {is_press ? STAT_NOTE_ON : STAT_NOTE_OFF, chan_cfg};
        ev.note_number = map_cfg[8 * (k % 8) +: 8];
        ev.velocity    = is_press ? VEL_ON : VEL_OFF;
        ev.last_event  = 1'b0;
        tick_events[n] = ev;
        n++;
      end
    end
    if (n > 0) tick_events[n - 1].last_event = 1'b1;
    return n;
  endfunction

  // Mostly a held button state with a few toggles, so lanes see clean edges.
  function automatic logic [7:0] next_levels();
    logic [7:0] flips;
    flips = '0;
    if ($urandom_range(9) < 7) begin
      for (int b = 0; b < 8; b++) begin
        if ($urandom_range(4) == 0) flips[b] = 1'b1;
      end
      held_levels = held_levels ^ flips;
    end else begin
      held_levels = 8'($urandom);
    end
    return held_levels;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    logic [15:0] t;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    unique case (idx)
      REG_LOCKOUT_TICKS: begin
        t = data[15:0];
        if (t == '0) t = 16'd1;
        if (32'(t) > CNT_MAX32) t = CNT_MAX32[15:0];
        ticks_cfg = t[COUNT_WIDTH-1:0];
      end
      REG_MIDI_CHANNEL: chan_cfg = data[3:0];
      REG_NOTE_MAP: map_cfg = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_sample(input logic [7:0] levels, input logic typed,
                             input logic [3:0] typed_count, input note_event_t typed_event);
    int gap;
    int n;
    note_event_t ev;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_button_levels <= levels;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    n = debounce_tick(levels);
    if (typed) begin
      for (int i = 0; i < typed_count; i++) begin
        ev = typed_event;
        ev.last_event = (i == typed_count - 1);
        pending_events.push_back(ev);
      end
    end else begin
      for (int i = 0; i < n; i++) pending_events.push_back(tick_events[i]);
    end
  endtask

  task automatic run_phase(input int items, input int s_pct, input int r_pct,
                           input int pause_every, input logic [63:0] ticks,
                           input logic [63:0] chan, input logic [63:0] map);
    drain();
    write_reg(REG_LOCKOUT_TICKS, ticks);
    write_reg(REG_MIDI_CHANNEL, chan);
    write_reg(REG_NOTE_MAP, map);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < items; i++) begin
      if (pause_every > 0 && i > 0 && i % pause_every == 0) begin
        drain();
        drain_pauses++;
      end
      send_sample(next_levels(), 1'b0, 4'd0, NO_EVENT);
    end
  endtask

  always @(posedge clk) begin : result_check
    note_event_t got;
    note_event_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_code_index, out_status_byte, out_note_number, out_velocity, out_last_event};
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected event at cycle %0d: code %0d status %02h note %02h",
                   cycle_count, got.code_index, got.status_byte, got.note_number);
          $display("  vel %0d last %0b", got.velocity, got.last_event);
        end
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at cycle %0d: expected code %0d status %02h note %02h",
                     cycle_count, want.code_index, want.status_byte, want.note_number);
            $display("  expected vel %0d last %0b", want.velocity, want.last_event);
            $display("  got code %0d status %02h note %02h vel %0d last %0b",
                     got.code_index, got.status_byte, got.note_number,
                     got.velocity, got.last_event);
          end
        end
        if (want.code_index == CIN_NOTE_ON) begin
          notes_on++;
        end else begin
          notes_off++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t row;
    for (int k = 0; k < LANES; k++) begin
      lane_phase[k] = PH_IDLE_UP;
      lane_count[k] = '0;
    end
    ticks_cfg = LOCKOUT_RESET[COUNT_WIDTH-1:0];
    chan_cfg = '0;
    map_cfg = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.reg_index, row.wdata);
      end else begin
        send_sample(row.levels, row.typed, row.typed_count, row.typed_event);
      end
    end

    run_phase(90, 27, 85, 0, 64'($urandom_range(1, 4)), 64'($urandom_range(15)),
              {$urandom, $urandom});
    run_phase(90, 85, 27, 30, 64'd2, 64'd0, 64'd0);
    run_phase(110, 0, 0, 0, 64'($urandom_range(0, 6)), 64'($urandom_range(15)),
              {$urandom, $urandom});
    run_phase(30, 0, 0, 0, 64'h0000_0000_0000_FFFF, 64'd15, {$urandom, $urandom});

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d samples over directed rows and four random phases,",
             samples_sent);
    $display("%0d register writes, %0d drain pauses.", reg_writes, drain_pauses);
    $display("Checked %0d note-on and %0d note-off events; %0d mismatches.",
             notes_on, notes_off, mismatches);
    if (mismatches == 0) begin
      $display("button_debounce_note_events regression: pass");
    end else begin
      $display("button_debounce_note_events regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bdne_pkg.sv
rtl/bdne_lane.sv
rtl/bdne_merge.sv
rtl/button_debounce_note_events.sv
rtl/bdne_checker.sv
tb/button_debounce_note_events_tb.sv
